// ===== rtl/prt_pkg.sv =====
// ----------------------------------------------------------------------------
// prt_pkg: shared definitions for the pending request table
// Field widths, reset values, opcodes and the slot entry layout.
// ----------------------------------------------------------------------------
package prt_pkg;

  // field widths
  localparam int unsigned AddrWidth  = 32;
  localparam int unsigned SeqWidth   = 16;
  localparam int unsigned DecayWidth = 8;

  // stream payload widths, padded to whole bytes
  localparam int unsigned InDataWidth  = 48;
  localparam int unsigned OutDataWidth = 48;

  // defaults
  localparam int unsigned DefaultTableSlots = 8;
  localparam logic [DecayWidth-1:0] DecayLimitReset = 8'd16;

  // request kinds carried in the input tuser
  localparam logic OpAllocate = 1'b0;
  localparam logic OpResolve  = 1'b1;

  // one slot of the table memory
  typedef struct packed {
    logic [AddrWidth-1:0]  addr;
    logic [SeqWidth-1:0]   seq;
    logic [DecayWidth-1:0] decay;
  } slot_entry_t;

endpackage

// ===== rtl/pending_request_table.sv =====
// ----------------------------------------------------------------------------
// pending_request_table
// Table of outstanding address-resolution requests with allocate and
// resolve scans that age the live slots they pass.
// ----------------------------------------------------------------------------
// Each request walks the slots in order, one slot per clock, through the
// single registered read port of the slot memory, with aging write-backs on
// its one write port. A request is accepted, visits the slots (TABLE_SLOTS
// at most, fewer when a match ends the scan), an allocate with no match
// claims a free slot, and the result goes out when the output is free.
// A new request is taken while the previous result still waits on the
// output. Slot liveness sits in flip-flops cleared by reset, so the table
// is usable right after reset. The user writes the decay limit through
// cfg_we_i / cfg_wdata_i only while idle; the block does not enforce it.
module pending_request_table #(
  parameter int unsigned TABLE_SLOTS = prt_pkg::DefaultTableSlots
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration: decay_limit
  input  logic                              cfg_we_i,
  input  logic [prt_pkg::DecayWidth-1:0]    cfg_wdata_i,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // tdata: target_address [31:0], reply_sequence [47:32]
  input  logic [prt_pkg::InDataWidth-1:0]   s_axis_tdata,
  // tuser: opcode [0]
  input  logic                              s_axis_tuser,
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // tdata: result_sequence [15:0], result_address [47:16]
  output logic [prt_pkg::OutDataWidth-1:0]  m_axis_tdata,
  // tuser: found [0]
  output logic                              m_axis_tuser
);

  import prt_pkg::*;

  localparam int unsigned IdxWidth = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam logic [IdxWidth-1:0] LastIdx = IdxWidth'(TABLE_SLOTS - 1);

  typedef enum logic [1:0] {
    StIdle,
    StScan,
    StAlloc,
    StResult
  } state_e;

  state_e                  state_q, state_d;
  logic [IdxWidth-1:0]     idx_q, idx_d;
  logic                    op_q, op_d;
  logic [AddrWidth-1:0]    target_q, target_d;
  logic [SeqWidth-1:0]     reply_q, reply_d;
  logic                    have_free_q, have_free_d;
  logic [IdxWidth-1:0]     free_idx_q, free_idx_d;
  logic [TABLE_SLOTS-1:0]  live_q, live_d;
  logic [SeqWidth-1:0]     next_seq_q, next_seq_d;
  logic [DecayWidth-1:0]   decay_limit_q, decay_limit_d;
  logic                    res_found_q, res_found_d;
  logic [SeqWidth-1:0]     res_seq_q, res_seq_d;
  logic [AddrWidth-1:0]    res_addr_q, res_addr_d;
  logic                    out_valid_q, out_valid_d;
  logic                    out_found_q, out_found_d;
  logic [SeqWidth-1:0]     out_seq_q, out_seq_d;
  logic [AddrWidth-1:0]    out_addr_q, out_addr_d;

  // slot memory ports
  slot_entry_t             slot_mem [TABLE_SLOTS];
  slot_entry_t             rdata_q;
  logic [IdxWidth-1:0]     mem_raddr;
  logic                    mem_we;
  logic [IdxWidth-1:0]     mem_waddr;
  slot_entry_t             mem_wdata;

  // scan helpers
  logic                    slot_live;
  logic                    age_frees;
  logic                    finish;
  logic [SeqWidth-1:0]     seq_inc;

  // slot memory, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      slot_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= slot_mem[mem_raddr];
  end

  assign slot_live = live_q[idx_q];
  assign age_frees = (rdata_q.decay <= DecayWidth'(1));
  assign seq_inc   = next_seq_q + SeqWidth'(1);

  // sequencer next state
  always_comb begin
    state_d       = state_q;
    idx_d         = idx_q;
    op_d          = op_q;
    target_d      = target_q;
    reply_d       = reply_q;
    have_free_d   = have_free_q;
    free_idx_d    = free_idx_q;
    live_d        = live_q;
    next_seq_d    = next_seq_q;
    decay_limit_d = decay_limit_q;
    res_found_d   = res_found_q;
    res_seq_d     = res_seq_q;
    res_addr_d    = res_addr_q;
    out_valid_d   = out_valid_q;
    out_found_d   = out_found_q;
    out_seq_d     = out_seq_q;
    out_addr_d    = out_addr_q;
    finish        = 1'b0;

    mem_raddr       = idx_q + IdxWidth'(1);
    mem_we          = 1'b0;
    mem_waddr       = idx_q;
    mem_wdata.addr  = rdata_q.addr;
    mem_wdata.seq   = rdata_q.seq;
    mem_wdata.decay = rdata_q.decay - DecayWidth'(1);

    // output beat taken
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    // register write
    if (cfg_we_i) begin
      decay_limit_d = cfg_wdata_i;
    end

    case (state_q)
      StIdle: begin
        mem_raddr = '0;
        if (s_axis_tvalid) begin
          op_d        = s_axis_tuser;
          target_d    = s_axis_tdata[AddrWidth-1:0];
          reply_d     = s_axis_tdata[AddrWidth +: SeqWidth];
          idx_d       = '0;
          have_free_d = 1'b0;
          free_idx_d  = '0;
          res_found_d = 1'b0;
          res_seq_d   = '0;
          res_addr_d  = '0;
          state_d     = StScan;
        end
      end

      StScan: begin
        if (op_q == OpAllocate) begin
          if (!slot_live) begin
            // empty slot, first one is the claim candidate
            if (!have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = idx_q;
            end
          end else if (rdata_q.addr == target_q) begin
            // address already pending
            res_found_d = (rdata_q.seq != '0);
            res_seq_d   = rdata_q.seq;
            finish      = 1'b1;
          end else if (age_frees) begin
            live_d[idx_q] = 1'b0;
            if (!have_free_q) begin
              have_free_d = 1'b1;
              free_idx_d  = idx_q;
            end
          end else begin
            mem_we = 1'b1;
          end
        end else begin
          if (slot_live) begin
            // age the slot, matched or not
            if (age_frees) begin
              live_d[idx_q] = 1'b0;
            end else begin
              mem_we = 1'b1;
            end
            if (rdata_q.seq == reply_q) begin
              res_found_d = (rdata_q.addr != '0);
              res_addr_d  = rdata_q.addr;
              finish      = 1'b1;
            end
          end
        end

        if (finish) begin
          state_d = StResult;
        end else if (idx_q == LastIdx) begin
          state_d = ((op_q == OpAllocate) && have_free_d) ? StAlloc : StResult;
        end else begin
          idx_d = idx_q + IdxWidth'(1);
        end
      end

      StAlloc: begin
        // fresh sequence, wrapping past zero
        next_seq_d         = (seq_inc == '0) ? SeqWidth'(1) : seq_inc;
        mem_we             = 1'b1;
        mem_waddr          = free_idx_q;
        mem_wdata.addr     = target_q;
        mem_wdata.seq      = next_seq_d;
        mem_wdata.decay    = decay_limit_q;
        live_d[free_idx_q] = (target_q != '0);
        res_found_d        = 1'b1;
        res_seq_d          = next_seq_d;
        state_d            = StResult;
      end

      StResult: begin
        // load the output register once it is free
        if (!out_valid_q || m_axis_tready) begin
          out_valid_d = 1'b1;
          out_found_d = res_found_q;
          out_seq_d   = res_seq_q;
          out_addr_d  = res_addr_q;
          state_d     = StIdle;
        end
      end

      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // state and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= StIdle;
      idx_q         <= '0;
      op_q          <= OpAllocate;
      target_q      <= '0;
      reply_q       <= '0;
      have_free_q   <= 1'b0;
      free_idx_q    <= '0;
      live_q        <= '0;
      next_seq_q    <= '0;
      decay_limit_q <= DecayLimitReset;
      res_found_q   <= 1'b0;
      res_seq_q     <= '0;
      res_addr_q    <= '0;
      out_valid_q   <= 1'b0;
      out_found_q   <= 1'b0;
      out_seq_q     <= '0;
      out_addr_q    <= '0;
    end else begin
      state_q       <= state_d;
      idx_q         <= idx_d;
      op_q          <= op_d;
      target_q      <= target_d;
      reply_q       <= reply_d;
      have_free_q   <= have_free_d;
      free_idx_q    <= free_idx_d;
      live_q        <= live_d;
      next_seq_q    <= next_seq_d;
      decay_limit_q <= decay_limit_d;
      res_found_q   <= res_found_d;
      res_seq_q     <= res_seq_d;
      res_addr_q    <= res_addr_d;
      out_valid_q   <= out_valid_d;
      out_found_q   <= out_found_d;
      out_seq_q     <= out_seq_d;
      out_addr_q    <= out_addr_d;
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_addr_q, out_seq_q};
  assign m_axis_tuser  = out_found_q;

endmodule
